>>> sv/lde_pkg.sv
// Package for the RGB565 line drawing engine.
// Holds the command types, the queue entry, the state enums and the blend function.
// Has no dependencies; every other file of the engine but the two interfaces imports it.
`default_nettype none

package lde_pkg;

	// Command codes as carried in the action field.
	typedef enum logic [1:0] {
		ACT_WRITE  = 2'd0,
		ACT_READ   = 2'd1,
		ACT_LINE   = 2'd2,
		ACT_SMOOTH = 2'd3
	} action_t;

	// Walker coordinates are signed so that neighbours just off the frame stay representable.
	localparam int CW = 13;
	typedef logic signed [CW-1:0] coord_t;

	// Alpha arithmetic.
	localparam int AW_ALPHA = 20;
	localparam logic signed [AW_ALPHA-1:0] ALPHA_FULL = 20'sd255;
	localparam logic signed [AW_ALPHA-1:0] ALPHA_HALF = 20'sd127;

	// Divider for the alpha step: a 17-bit dividend, one quotient bit per cycle.
	localparam int DIV_N     = 17;
	localparam int DIV_D     = 10;
	localparam int DIV_CNT_W = 5;

	// Decoded command as it travels through the queue.
	typedef struct packed {
		action_t           action;
		logic [8:0]        x1;
		logic [8:0]        y1;
		logic [8:0]        x2;
		logic [8:0]        y2;
		logic [15:0]       pen;
		logic [8:0]        dx;
		logic [8:0]        dy;
		logic signed [1:0] sx;
		logic signed [1:0] sy;
		logic              x_major;
		logic signed [9:0] astep;
	} cmd_t;

	// Front end to queue.
	typedef struct packed {
		logic push;
		cmd_t entry;
	} q_wr_t;

	// Queue to back end.
	typedef struct packed {
		logic valid;
		cmd_t entry;
	} q_rd_t;

	// Queue status.
	typedef struct packed {
		logic       full;
		logic       empty;
		logic [1:0] count;
	} q_stat_t;

	localparam logic [1:0] QUEUE_DEPTH = 2'd2;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DINIT,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_WRITE,
		B_READ,
		B_RDWAIT,
		B_PX,
		B_PY,
		B_S1,
		B_S2,
		B_S3
	} back_state_t;

	// Per-channel blend of the pen over a stored pixel with weights wa and 255-wa.
	function automatic logic [15:0] lde_blend(logic [15:0] pen, logic [15:0] pix,
			logic [7:0] wa);
		logic [7:0]  wb;
		logic [15:0] sr;
		logic [15:0] sg;
		logic [15:0] sb;
		wb = ~wa;
		sr = 16'(wa * {pen[15:11], 3'b000}) + 16'(wb * {pix[15:11], 3'b000});
		sg = 16'(wa * {pen[10:5], 2'b00}) + 16'(wb * {pix[10:5], 2'b00});
		sb = 16'(wa * {pen[4:0], 3'b000}) + 16'(wb * {pix[4:0], 3'b000});
		return {sr[15:11], sg[15:10], sb[15:11]};
	endfunction

endpackage

`default_nettype wire

>>> sv/lde_cmd_if.sv
// Command channel of the line drawing engine: valid/ready and the command fields.
// No dependencies.
`default_nettype none

interface lde_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [8:0]  start_x;
	logic [8:0]  start_y;
	logic [8:0]  end_x;
	logic [8:0]  end_y;
	logic [15:0] pen_colour;

	modport source (output valid, action, start_x, start_y, end_x, end_y, pen_colour,
		input ready);
	modport sink (input valid, action, start_x, start_y, end_x, end_y, pen_colour,
		output ready);
endinterface

`default_nettype wire

>>> sv/lde_rsp_if.sv
// Response channel of the line drawing engine: valid/ready and the read pixel value.
// No dependencies.
`default_nettype none

interface lde_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] pixel_value;

	modport source (output valid, pixel_value, input ready);
	modport sink (input valid, pixel_value, output ready);
endinterface

`default_nettype wire

>>> sv/lde_front.sv
// Front end: takes commands, works out deltas and directions, and runs the
// alpha step division for smooth lines. Depends on lde_pkg and lde_cmd_if.
`default_nettype none

module lde_front (
	input  logic         clk,
	input  logic         arst_n,
	lde_cmd_if.sink      cmd,
	output lde_pkg::q_wr_t wr,
	input  logic         full
);
	import lde_pkg::*;

	front_state_t         state_q, state_d;
	action_t              action_q;
	logic [8:0]           x1_q, y1_q, x2_q, y2_q;
	logic [15:0]          pen_q;
	logic [DIV_D-1:0]     rem_q, rem_d;
	logic [DIV_N-1:0]     quo_q, quo_d;
	logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

	logic [8:0]        dx, dy, dmaj, dmin;
	logic signed [1:0] sx, sy;
	logic              x_major;
	logic [DIV_N-1:0]  num;
	logic [DIV_D-1:0]  den;
	logic [DIV_D:0]    trial;
	logic [7:0]        q;
	logic signed [9:0] astep;
	logic              take;

	assign take      = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == F_IDLE);

	// Deltas and directions of the held command.
	always_comb begin
		dx = (x2_q >= x1_q) ? x2_q - x1_q : x1_q - x2_q;
		dy = (y2_q >= y1_q) ? y2_q - y1_q : y1_q - y2_q;
		sx = (x2_q > x1_q) ? 2'sd1 : ((x2_q < x1_q) ? -2'sd1 : 2'sd0);
		sy = (y2_q > y1_q) ? 2'sd1 : ((y2_q < y1_q) ? -2'sd1 : 2'sd0);
		x_major = (dy < dx);
		dmaj = x_major ? dx : dy;
		dmin = x_major ? dy : dx;
		num  = {dmin, 8'd0} - DIV_N'(dmin);
		den  = DIV_D'(dmaj) + 1'b1;
		trial = {rem_q, quo_q[DIV_N-1]};
		q = quo_q[7:0];
		if (x_major || sx > 0) begin
			astep = -$signed({2'b00, q});
		end else if (sx < 0) begin
			astep = $signed({2'b00, q});
		end else begin
			astep = 10'sd0;
		end
	end

	// Command register.
	always_ff @(posedge clk) begin
		if (take) begin
			action_q <= action_t'(cmd.action);
			x1_q     <= cmd.start_x;
			y1_q     <= cmd.start_y;
			x2_q     <= cmd.end_x;
			y2_q     <= cmd.end_y;
			pen_q    <= cmd.pen_colour;
		end
	end

	// Divider registers.
	always_ff @(posedge clk) begin
		rem_q <= rem_d;
		quo_q <= quo_d;
	end

	// State and step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state, one restoring division step per cycle, and the queue push.
	always_comb begin
		state_d  = state_q;
		rem_d    = rem_q;
		quo_d    = quo_q;
		cnt_d    = cnt_q;
		wr.push  = 1'b0;
		wr.entry = '{action: action_q, x1: x1_q, y1: y1_q, x2: x2_q, y2: y2_q,
			pen: pen_q, dx: dx, dy: dy, sx: sx, sy: sy, x_major: x_major,
			astep: astep};
		unique case (state_q)
			F_IDLE: begin
				if (take) begin
					state_d = (action_t'(cmd.action) == ACT_SMOOTH) ? F_DINIT : F_PUSH;
				end
			end
			F_DINIT: begin
				rem_d   = '0;
				quo_d   = num;
				cnt_d   = '0;
				state_d = F_DIV;
			end
			F_DIV: begin
				if (trial >= {1'b0, den}) begin
					rem_d = DIV_D'(trial - {1'b0, den});
					quo_d = {quo_q[DIV_N-2:0], 1'b1};
				end else begin
					rem_d = trial[DIV_D-1:0];
					quo_d = {quo_q[DIV_N-2:0], 1'b0};
				end
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_N - 1)) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!full) begin
					wr.push = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

endmodule

`default_nettype wire

>>> sv/lde_queue.sv
// Two-entry queue of decoded commands between the front and back ends.
// Depends on lde_pkg.
`default_nettype none

module lde_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  lde_pkg::q_wr_t wr,
	output lde_pkg::q_rd_t rd,
	input  logic           pop,
	output lde_pkg::q_stat_t stat
);
	import lde_pkg::*;

	cmd_t       store_q [2];
	logic       wp_q, rp_q;
	logic [1:0] count_q;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr.push) begin
			store_q[wp_q] <= wr.entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= 1'b0;
			rp_q    <= 1'b0;
			count_q <= '0;
		end else begin
			if (wr.push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			count_q <= count_q + {1'b0, wr.push} - {1'b0, pop};
		end
	end

	assign rd.valid   = (count_q != 2'd0);
	assign rd.entry   = store_q[rp_q];
	assign stat.full  = (count_q == QUEUE_DEPTH);
	assign stat.empty = (count_q == 2'd0);
	assign stat.count = count_q;

endmodule

`default_nettype wire

>>> sv/lde_back.sv
// Back end: owns the frame store and walks pixel, line and smooth line commands.
// Depends on lde_pkg and lde_rsp_if.
`default_nettype none

module lde_back #(
	parameter int FRAME_WIDTH  = 512,
	parameter int FRAME_HEIGHT = 272
) (
	input  logic           clk,
	input  logic           arst_n,
	input  lde_pkg::q_rd_t rd,
	output logic           pop,
	lde_rsp_if.source      rsp
);
	import lde_pkg::*;

	localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	logic [15:0] mem [DEPTH];
	logic [15:0] rdata_q;

	back_state_t       state_q, state_d;
	coord_t            x_q, y_q, x_d, y_d, x2_q, y2_q, x2_d, y2_d;
	logic [15:0]       pen_q, pen_d;
	logic [8:0]        dx_q, dy_q, dx_d, dy_d, n_q, n_d;
	logic signed [1:0] sx_q, sy_q, sx_d, sy_d;
	logic              xmaj_q, xmaj_d;
	logic signed [9:0] astep_q, astep_d;
	logic [10:0]       acc_q, acc_d;
	logic signed [AW_ALPHA-1:0] alpha_q, alpha_d;
	logic              rd_in_q, rd_in_d;
	logic              out_valid_q, out_valid_d;
	logic [15:0]       out_data_q, out_data_d;

	logic              we;
	logic [AW-1:0]     waddr, raddr;
	logic [15:0]       wdata;
	coord_t            ydir, ax, ay, bx, by;
	logic [10:0]       acc_x, acc_y;
	logic signed [AW_ALPHA-1:0] alpha_b, alpha_inc;
	logic [7:0]        wa_a, wa_b;
	logic [15:0]       blend_a, blend_b;
	cmd_t              c;

	function automatic logic in_frame(coord_t x, coord_t y);
		return (x >= 0) && (y >= 0) && (x < coord_t'(FRAME_WIDTH))
			&& (y < coord_t'(FRAME_HEIGHT));
	endfunction

	function automatic logic [AW-1:0] addr_of(coord_t x, coord_t y);
		return AW'(int'(y) * FRAME_WIDTH + int'(x));
	endfunction

	function automatic logic [7:0] sat(logic signed [AW_ALPHA-1:0] a);
		if (a < 0) begin
			return 8'd0;
		end else if (a > ALPHA_FULL) begin
			return 8'd255;
		end else begin
			return a[7:0];
		end
	endfunction

	// Frame store: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// Walker registers.
	always_ff @(posedge clk) begin
		x_q     <= x_d;
		y_q     <= y_d;
		x2_q    <= x2_d;
		y2_q    <= y2_d;
		pen_q   <= pen_d;
		dx_q    <= dx_d;
		dy_q    <= dy_d;
		n_q     <= n_d;
		sx_q    <= sx_d;
		sy_q    <= sy_d;
		xmaj_q  <= xmaj_d;
		astep_q <= astep_d;
		acc_q   <= acc_d;
		alpha_q <= alpha_d;
		rd_in_q <= rd_in_d;
		out_data_q <= out_data_d;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.pixel_value = out_data_q;

	// Neighbour positions, Bresenham sums and blends of the current step.
	always_comb begin
		c    = rd.entry;
		ydir = (sy_q < 0) ? -coord_t'(1) : coord_t'(1);
		ax   = xmaj_q ? x_q : x_q - coord_t'(1);
		ay   = xmaj_q ? y_q - ydir : y_q;
		bx   = xmaj_q ? x_q : x_q + coord_t'(1);
		by   = xmaj_q ? y_q + ydir : y_q;
		acc_x = acc_q + {2'b00, dy_q};
		acc_y = acc_q + {2'b00, dx_q};
		alpha_b   = ALPHA_FULL - alpha_q;
		alpha_inc = {{(AW_ALPHA-10){astep_q[9]}}, astep_q};
		wa_a    = sat(alpha_q);
		wa_b    = sat(alpha_b);
		blend_a = lde_blend(pen_q, rdata_q, wa_a);
		blend_b = lde_blend(pen_q, rdata_q, wa_b);
	end

	// Sequencer: next state, memory accesses and walker updates.
	always_comb begin
		state_d = state_q;
		x_d = x_q; y_d = y_q; x2_d = x2_q; y2_d = y2_q;
		pen_d = pen_q; dx_d = dx_q; dy_d = dy_q; n_d = n_q;
		sx_d = sx_q; sy_d = sy_q; xmaj_d = xmaj_q; astep_d = astep_q;
		acc_d = acc_q; alpha_d = alpha_q; rd_in_d = rd_in_q;
		out_data_d  = out_data_q;
		out_valid_d = out_valid_q && !rsp.ready;
		pop   = 1'b0;
		we    = 1'b0;
		waddr = addr_of(x_q, y_q);
		wdata = pen_q;
		raddr = addr_of(x_q, y_q);
		unique case (state_q)
			B_IDLE: begin
				if (rd.valid) begin
					pop     = 1'b1;
					x_d     = coord_t'({1'b0, c.x1});
					y_d     = coord_t'({1'b0, c.y1});
					x2_d    = coord_t'({1'b0, c.x2});
					y2_d    = coord_t'({1'b0, c.y2});
					pen_d   = c.pen;
					dx_d    = c.dx;
					dy_d    = c.dy;
					sx_d    = c.sx;
					sy_d    = c.sy;
					xmaj_d  = c.x_major;
					astep_d = c.astep;
					alpha_d = ALPHA_HALF;
					unique case (c.action)
						ACT_WRITE: state_d = B_WRITE;
						ACT_READ:  state_d = B_READ;
						ACT_LINE: begin
							acc_d   = c.x_major ? {3'b000, c.dx[8:1]} : {3'b000, c.dy[8:1]};
							state_d = c.x_major ? B_PX : B_PY;
						end
						ACT_SMOOTH: begin
							n_d     = c.x_major ? c.dx : c.dy;
							acc_d   = c.x_major ? {3'b000, c.dx[8:1]} : {3'b000, c.dy[8:1]};
							state_d = ((c.x_major ? c.dx : c.dy) == 9'd0) ? B_IDLE : B_S1;
						end
						default: state_d = B_IDLE;
					endcase
				end
			end
			B_WRITE: begin
				we      = in_frame(x_q, y_q);
				state_d = B_IDLE;
			end
			// Wait for the output register to be free, then read.
			B_READ: begin
				if (!out_valid_q || rsp.ready) begin
					rd_in_d = in_frame(x_q, y_q);
					state_d = B_RDWAIT;
				end
			end
			B_RDWAIT: begin
				out_data_d  = rd_in_q ? rdata_q : 16'd0;
				out_valid_d = 1'b1;
				state_d     = B_IDLE;
			end
			// Plain line, x-major phase: draw, then step unless at the end column.
			B_PX: begin
				we = in_frame(x_q, y_q);
				if (x_q == x2_q) begin
					acc_d   = {3'b000, dy_q[8:1]};
					state_d = B_PY;
				end else begin
					if (acc_x > {2'b00, dx_q}) begin
						acc_d = acc_x - {2'b00, dx_q};
						y_d   = y_q + coord_t'(sy_q);
					end else begin
						acc_d = acc_x;
					end
					x_d = x_q + coord_t'(sx_q);
				end
			end
			// Plain line, y-major phase.
			B_PY: begin
				we = in_frame(x_q, y_q);
				if (y_q == y2_q) begin
					state_d = B_IDLE;
				end else begin
					if (acc_y > {2'b00, dy_q}) begin
						acc_d = acc_y - {2'b00, dy_q};
						x_d   = x_q + coord_t'(sx_q);
					end else begin
						acc_d = acc_y;
					end
					y_d = y_q + coord_t'(sy_q);
				end
			end
			// Smooth line: solid centre while the first neighbour is read.
			B_S1: begin
				we      = in_frame(x_q, y_q);
				raddr   = addr_of(ax, ay);
				state_d = B_S2;
			end
			// First neighbour blended while the second is read.
			B_S2: begin
				we      = in_frame(ax, ay);
				waddr   = addr_of(ax, ay);
				wdata   = blend_a;
				raddr   = addr_of(bx, by);
				state_d = B_S3;
			end
			// Second neighbour blended, then the walker steps.
			B_S3: begin
				we      = in_frame(bx, by);
				waddr   = addr_of(bx, by);
				wdata   = blend_b;
				alpha_d = alpha_q + alpha_inc;
				n_d     = n_q - 1'b1;
				if (xmaj_q) begin
					x_d = x_q + coord_t'(sx_q);
					if (acc_x > {2'b00, dx_q}) begin
						acc_d   = acc_x - {2'b00, dx_q};
						alpha_d = (astep_q < 0) ? ALPHA_FULL : '0;
						y_d     = y_q + ydir;
					end else begin
						acc_d = acc_x;
					end
				end else begin
					y_d = y_q + ydir;
					if (acc_y > {2'b00, dy_q}) begin
						acc_d   = acc_y - {2'b00, dy_q};
						alpha_d = (astep_q < 0) ? ALPHA_FULL : '0;
						x_d     = x_q + coord_t'(sx_q);
					end else begin
						acc_d = acc_y;
					end
				end
				state_d = (n_q == 9'd1) ? B_IDLE : B_S1;
			end
			default: state_d = B_IDLE;
		endcase
	end

endmodule

`default_nettype wire

>>> sv/line_draw_engine_rgb565_top.sv
// Top level of the RGB565 line drawing engine: front end, command queue, back end.
// Depends on lde_pkg, lde_cmd_if, lde_rsp_if, lde_front, lde_queue and lde_back.
// A pixel write passes the front end's command register, the queue and the back end's
// write state before it reaches the frame store. A read passes the back end's read and
// read-wait states, and its result is held in the registered output until it is taken.
// The front end takes no new command until it has pushed the last one into the queue,
// and for a smooth line it first runs the alpha step division; the back end walks one
// command from the queue at a time.
// Reset clears the control state only; the frame store holds whatever was last written.
`default_nettype none

module line_draw_engine_rgb565_top #(
	parameter int FRAME_WIDTH  = 512,
	parameter int FRAME_HEIGHT = 272
) (
	input  logic       clk,
	input  logic       arst_n,
	lde_cmd_if.sink    cmd,
	lde_rsp_if.source  rsp
);
	import lde_pkg::*;

	q_wr_t   q_wr;
	q_rd_t   q_rd;
	q_stat_t q_stat;
	logic    q_pop;

	// Command decode and alpha step division.
	lde_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.wr     (q_wr),
		.full   (q_stat.full)
	);

	// Queue between the two halves.
	lde_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.rd     (q_rd),
		.pop    (q_pop),
		.stat   (q_stat)
	);

	// Frame store and line walker.
	lde_back #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (q_rd),
		.pop    (q_pop),
		.rsp    (rsp)
	);

	// The front end never pushes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr.push |-> !q_stat.full)
		else $error("queue push while full");

	// The back end never pops an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_rd.valid)
		else $error("queue pop while empty");

	// The fill count stays within the queue depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count != 2'd3)
		else $error("queue count out of range");

endmodule

`default_nettype wire

>>> tb/line_draw_engine_rgb565_top_tb.sv
// Self-checking testbench for the RGB565 line drawing engine.
// It drives commands on lde_cmd_if, checks read results on lde_rsp_if against its own
// frame store predictor; depends on lde_pkg, both interfaces and the top level.
`default_nettype none

module line_draw_engine_rgb565_top_tb;
	import lde_pkg::*;

	localparam int FW = 512;
	localparam int FH = 272;
	localparam int FULL_ALPHA = 255;
	localparam int SETTLE_CYCLES = 2000;
	localparam longint CYCLE_LIMIT = 3000000;

	logic clk;
	logic arst_n;
	lde_cmd_if cmd_ch();
	lde_rsp_if rsp_ch();

	line_draw_engine_rgb565_top #(.FRAME_WIDTH(FW), .FRAME_HEIGHT(FH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rsp(rsp_ch)
	);

	logic [15:0] frame_model [FW*FH];
	logic [15:0] pending_reads[$];
	int errors;
	bit calm;
	int rdy_wait;
	int stall_left;
	longint cycles;

	// Clock.
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Run watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout at %0t", $time);
			$display("line_draw_engine_rgb565_top_tb: errors");
			$finish;
		end
	end

	// ---------------- predictor ----------------

	function automatic void paint_pixel(int x, int y, logic [15:0] pen);
		if (x >= 0 && y >= 0 && x < FW && y < FH)
			frame_model[y*FW + x] = pen;
	endfunction

	function automatic void blend_into(int x, int y, logic [15:0] pen, int wa);
		int wb, p, c, sr, sg, sb;
		if (!(x >= 0 && y >= 0 && x < FW && y < FH))
			return;
		if (wa < 0) wa = 0;
		if (wa > FULL_ALPHA) wa = FULL_ALPHA;
		wb = FULL_ALPHA - wa;
		p = frame_model[y*FW + x];
		c = pen;
		sr = wa * ((c >> 8) & 'hf8) + wb * ((p >> 8) & 'hf8);
		sg = wa * ((c >> 3) & 'hfc) + wb * ((p >> 3) & 'hfc);
		sb = wa * ((c << 3) & 'hf8) + wb * ((p << 3) & 'hf8);
		frame_model[y*FW + x] = 16'((sr & 'hf800) | ((sg >> 5) & 'h07e0) | ((sb >> 11) & 'h001f));
	endfunction

	function automatic int sgn(int v);
		return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
	endfunction

	function automatic int mag(int v);
		return (v < 0) ? -v : v;
	endfunction

	// Plain line: an x-major phase for shallow lines, then the y-major phase.
	function automatic void trace_plain(int x, int y, int x2, int y2, logic [15:0] pen);
		int dx, dy, sx, sy, acc;
		dx = mag(x2 - x);
		dy = mag(y2 - y);
		sx = sgn(x2 - x);
		sy = sgn(y2 - y);
		if (dy < dx) begin
			acc = dx >> 1;
			while (x != x2) begin
				paint_pixel(x, y, pen);
				acc += dy;
				if (acc > dx) begin
					acc -= dx;
					y += sy;
				end
				x += sx;
			end
			paint_pixel(x, y, pen);
		end
		acc = dy >> 1;
		while (y != y2) begin
			paint_pixel(x, y, pen);
			acc += dx;
			if (acc > dy) begin
				acc -= dy;
				x += sx;
			end
			y += sy;
		end
		paint_pixel(x, y, pen);
	endfunction

	// Smooth line: three pixels per step across the minor axis, alpha ramps between steps.
	function automatic void trace_smooth(int x, int y, int x2, int y2, logic [15:0] pen);
		int dx, dy, sx, sy, ydir, acc, alpha, astep, areset, n;
		dx = mag(x2 - x);
		dy = mag(y2 - y);
		sx = sgn(x2 - x);
		sy = sgn(y2 - y);
		ydir = (sy < 0) ? -1 : 1;
		alpha = FULL_ALPHA >> 1;
		if (dy < dx) begin
			acc = dx >> 1;
			astep = -((FULL_ALPHA * dy) / (dx + 1));
			areset = (astep < 0) ? FULL_ALPHA : 0;
			for (n = dx; n > 0; n--) begin
				blend_into(x, y - ydir, pen, alpha);
				paint_pixel(x, y, pen);
				blend_into(x, y + ydir, pen, FULL_ALPHA - alpha);
				acc += dy;
				alpha += astep;
				x += sx;
				if (acc > dx) begin
					acc -= dx;
					alpha = areset;
					y += ydir;
				end
			end
		end else begin
			acc = dy >> 1;
			astep = -sx * ((FULL_ALPHA * dx) / (dy + 1));
			areset = (astep < 0) ? FULL_ALPHA : 0;
			for (n = dy; n > 0; n--) begin
				blend_into(x - 1, y, pen, alpha);
				paint_pixel(x, y, pen);
				blend_into(x + 1, y, pen, FULL_ALPHA - alpha);
				acc += dx;
				alpha += astep;
				y += ydir;
				if (acc > dy) begin
					acc -= dy;
					alpha = areset;
					x += sx;
				end
			end
		end
	endfunction

	function automatic void apply_command(action_t act, int x1, int y1, int x2, int y2,
			logic [15:0] pen);
		case (act)
			ACT_WRITE: paint_pixel(x1, y1, pen);
			ACT_READ: begin
				if (y1 < FH && x1 < FW)
					pending_reads.push_back(frame_model[y1*FW + x1]);
				else
					pending_reads.push_back(16'h0000);
			end
			ACT_LINE: trace_plain(x1, y1, x2, y2, pen);
			default: trace_smooth(x1, y1, x2, y2, pen);
		endcase
	endfunction

	// ---------------- response side ----------------

	// Ready may drop for a random stall after each transfer; in calm phases it stays high.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= 0;
		end else if (rsp_ch.valid && rsp_ch.ready) begin
			rdy_wait = calm ? 0 : $urandom_range(0, 6);
			if (rdy_wait > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left <= rdy_wait;
			end
		end else if (!rsp_ch.ready) begin
			if (stall_left <= 1)
				rsp_ch.ready <= 1'b1;
			stall_left <= stall_left - 1;
		end
	end

	// Each read result is compared with the oldest expected value.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_reads.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, actual %h", $time, rsp_ch.pixel_value);
			end else begin
				if (rsp_ch.pixel_value !== pending_reads[0]) begin
					errors++;
					$display("%0t: pixel_value expected %h actual %h", $time,
						pending_reads[0], rsp_ch.pixel_value);
				end
				void'(pending_reads.pop_front());
			end
		end
	end

	// ---------------- command side ----------------

	// Sends one command and updates the predictor when the transfer happens.
	task automatic send_cmd(action_t act, int x1, int y1, int x2, int y2, logic [15:0] pen);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.action <= act;
		cmd_ch.start_x <= 9'(x1);
		cmd_ch.start_y <= 9'(y1);
		cmd_ch.end_x <= 9'(x2);
		cmd_ch.end_y <= 9'(y2);
		cmd_ch.pen_colour <= pen;
		do @(posedge clk); while (!cmd_ch.ready);
		apply_command(act, x1, y1, x2, y2, pen);
	endtask

	// Holds the sender until every expected result has come back.
	task automatic wait_results_drained();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_reads.size() != 0);
	endtask

	function automatic int near(int v, int span, int top);
		int r;
		r = v + $urandom_range(0, 2*span) - span;
		if (r < 0) r = 0;
		if (r > top) r = top;
		return r;
	endfunction

	function automatic int rand_row();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(FH, 511) : $urandom_range(0, FH-1);
	endfunction

	// ---------------- tests ----------------

	// Every pixel is written by horizontal lines so no later access hits an unwritten entry.
	task automatic test_fill();
		calm = 1'b1;
		for (int y = 0; y < FH; y++)
			send_cmd(ACT_LINE, 0, y, FW-1, y, 16'($urandom));
		calm = 1'b0;
	endtask

	task automatic test_pixels();
		send_cmd(ACT_WRITE, 0, 0, 511, 511, 16'h0000);
		send_cmd(ACT_WRITE, FW-1, FH-1, 0, 0, 16'hffff);
		send_cmd(ACT_WRITE, 5, 400, 0, 0, 16'h1234);
		send_cmd(ACT_READ, 0, 0, 511, 511, 16'hffff);
		send_cmd(ACT_READ, FW-1, FH-1, 0, 0, 16'h0000);
		send_cmd(ACT_READ, 511, 511, 511, 511, 16'hffff);
	endtask

	task automatic test_plain_lines();
		send_cmd(ACT_LINE, 40, 40, 40, 40, 16'hf800);
		send_cmd(ACT_LINE, 10, 10, 30, 15, 16'h07e0);
		send_cmd(ACT_LINE, 30, 50, 12, 20, 16'h001f);
		send_cmd(ACT_LINE, 500, 260, 511, 300, 16'hffff);
		send_cmd(ACT_READ, 40, 40, 0, 0, 16'h0000);
		send_cmd(ACT_READ, 20, 12, 0, 0, 16'h0000);
	endtask

	task automatic test_smooth_lines();
		send_cmd(ACT_SMOOTH, 60, 60, 60, 60, 16'h1111);
		send_cmd(ACT_SMOOTH, 0, 0, 50, 0, 16'hffff);
		send_cmd(ACT_SMOOTH, 511, 100, 511, 140, 16'h0000);
		send_cmd(ACT_SMOOTH, 100, 100, 110, 103, 16'hf81f);
		send_cmd(ACT_SMOOTH, 100, 150, 97, 160, 16'h07ff);
		send_cmd(ACT_SMOOTH, 200, 200, 180, 170, 16'hffe0);
		send_cmd(ACT_SMOOTH, 300, 271, 320, 271, 16'h5a5a);
		send_cmd(ACT_READ, 0, 1, 0, 0, 16'h0000);
		send_cmd(ACT_READ, 105, 102, 0, 0, 16'h0000);
		send_cmd(ACT_READ, 97, 158, 0, 0, 16'h0000);
		wait_results_drained();
	endtask

	task automatic test_random(int count);
		int x1, y1, x2, y2, pick;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0)
				calm = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			x1 = $urandom_range(0, FW-1);
			y1 = rand_row();
			if ($urandom_range(0, 19) == 0) begin
				x2 = $urandom_range(0, FW-1);
				y2 = rand_row();
			end else begin
				x2 = near(x1, 24, FW-1);
				y2 = near(y1 < FH ? y1 : FH-1, 24, 511);
			end
			if (pick < 20)
				send_cmd(ACT_WRITE, x1, y1, x2, y2, 16'($urandom));
			else if (pick < 50)
				send_cmd(ACT_READ, x1, y1, x2, y2, 16'($urandom));
			else if (pick < 75)
				send_cmd(ACT_LINE, x1, y1, x2, y2, 16'($urandom));
			else
				send_cmd(ACT_SMOOTH, x1, y1, x2, y2, 16'($urandom));
		end
		calm = 1'b0;
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.action <= ACT_WRITE;
		cmd_ch.start_x <= '0;
		cmd_ch.start_y <= '0;
		cmd_ch.end_x <= '0;
		cmd_ch.end_y <= '0;
		cmd_ch.pen_colour <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill();
		test_pixels();
		test_plain_lines();
		test_smooth_lines();
		test_random(76);
		cmd_ch.valid <= 1'b0;
		while (pending_reads.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("line_draw_engine_rgb565_top_tb: clean");
		else
			$display("line_draw_engine_rgb565_top_tb: errors");
		$finish;
	end

endmodule

`default_nettype wire
